// ===== rtl/adfp_pkg.sv =====
package adfp_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned FRAC_W  = 60;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;

  // pipeline: capture, power lookup, four multiplier stages, sum, output
  localparam int unsigned NSTG    = 8;
  localparam int unsigned MUL_STG = 4;

  localparam logic [CNT_W-1:0] MAX_SCALE = 5'd18;
  localparam logic [CNT_W-1:0] CFG_RESET = 5'd8;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_WHOLE = 2'd1;
  localparam logic [1:0] PH_FRAC  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  function automatic logic [FRAC_W-1:0] pow_ten(input logic [CNT_W-1:0] e);
    logic [FRAC_W-1:0] r;
    unique case (e)
      5'd0:    r = 60'd1;
      5'd1:    r = 60'd10;
      5'd2:    r = 60'd100;
      5'd3:    r = 60'd1000;
      5'd4:    r = 60'd10000;
      5'd5:    r = 60'd100000;
      5'd6:    r = 60'd1000000;
      5'd7:    r = 60'd10000000;
      5'd8:    r = 60'd100000000;
      5'd9:    r = 60'd1000000000;
      5'd10:   r = 60'd10000000000;
      5'd11:   r = 60'd100000000000;
      5'd12:   r = 60'd1000000000000;
      5'd13:   r = 60'd10000000000000;
      5'd14:   r = 60'd100000000000000;
      5'd15:   r = 60'd1000000000000000;
      5'd16:   r = 60'd10000000000000000;
      5'd17:   r = 60'd100000000000000000;
      5'd18:   r = 60'd1000000000000000000;
      default: r = 60'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ascii_decimal_to_fixed_point_unit.sv =====
// ASCII decimal string to scaled signed integer.
//
// Input channel: one character per transaction on in_character, with
// in_is_last marking the final character of a string. Accepted when in_valid
// is high and in_stall is low. A new character can be taken every cycle while in_stall is low.
// Output channel: one out_mantissa per string, the value times
// 10^fraction_digits in two's complement, wrapping modulo 2^64.
// Configuration: cfg_wr_en/cfg_wr_data write fraction_digits (reset 8,
// values above 18 act as 18); write only between strings with the pipe empty.
//
// Throughput is one character per cycle while in_stall is low; the parser folds each digit
// into its accumulators with a combinational shift-add. After its last character is
// accepted, the result of a string passes the capture and power lookup stages, the
// final scale multiply (four stages of 32x32 partial products) and the sum and negate
// stages. Each pipeline stage advances independently, so characters keep flowing while
// a result waits on out_stall; in_stall rises only when every stage holds a result.
// Synchronous reset empties the pipeline, clears the parser and restores
// fraction_digits to 8.
module ascii_decimal_to_fixed_point_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [adfp_pkg::CHAR_W-1:0]        in_character,
  input  logic                               in_is_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [adfp_pkg::DATA_W-1:0] out_mantissa,
  input  logic                               cfg_wr_en,
  input  logic [adfp_pkg::CNT_W-1:0]         cfg_wr_data
);

  localparam int unsigned NSTG = adfp_pkg::NSTG;

  logic [adfp_pkg::CNT_W-1:0]  cfg_r;
  logic [adfp_pkg::CNT_W-1:0]  scale;

  logic [1:0]                  phase_r, phase_nxt;
  logic                        minus_r, minus_nxt;
  logic [adfp_pkg::DATA_W-1:0] whole_r, whole_nxt;
  logic [adfp_pkg::FRAC_W-1:0] frac_r, frac_nxt;
  logic [adfp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                         is_digit;
  logic [adfp_pkg::CHAR_W-1:0]  diff;
  logic [adfp_pkg::DIGIT_W-1:0] digit;
  logic [adfp_pkg::DATA_W-1:0]  whole_x10;
  logic [adfp_pkg::FRAC_W-1:0]  frac_x10;
  logic                         accept;

  logic [NSTG-1:0] en, v_r;
  logic [NSTG-2:0] sign_r;

  logic [adfp_pkg::DATA_W-1:0] p0_whole_r, p1_whole_r;
  logic [adfp_pkg::FRAC_W-1:0] p0_frac_r, p1_frac_r;
  logic [adfp_pkg::CNT_W-1:0]  p0_cnt_r, p0_scale_r, pad_exp;
  logic [adfp_pkg::FRAC_W-1:0] p1_pw_r, p1_pf_r;
  logic [adfp_pkg::DATA_W-1:0] whole_prod, frac_prod, sum_r, out_r;

  assign scale = (cfg_r > adfp_pkg::MAX_SCALE) ? adfp_pkg::MAX_SCALE : cfg_r;

  assign is_digit = (in_character >= adfp_pkg::CH_ZERO) && (in_character <= adfp_pkg::CH_NINE);
  assign diff     = in_character - adfp_pkg::CH_ZERO;
  assign digit    = diff[adfp_pkg::DIGIT_W-1:0];

  assign whole_x10 = {whole_r[adfp_pkg::DATA_W-4:0], 3'b000}
                   + {whole_r[adfp_pkg::DATA_W-2:0], 1'b0}
                   + adfp_pkg::DATA_W'(digit);
  assign frac_x10  = {frac_r[adfp_pkg::FRAC_W-4:0], 3'b000}
                   + {frac_r[adfp_pkg::FRAC_W-2:0], 1'b0}
                   + adfp_pkg::FRAC_W'(digit);

  always_comb begin
    phase_nxt = phase_r;
    minus_nxt = minus_r;
    whole_nxt = whole_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    unique case (phase_r)
      adfp_pkg::PH_START: begin
        priority if (in_character == adfp_pkg::CH_MINUS) begin
          minus_nxt = 1'b1;
          phase_nxt = adfp_pkg::PH_WHOLE;
        end else if (is_digit) begin
          whole_nxt = adfp_pkg::DATA_W'(digit);
          phase_nxt = adfp_pkg::PH_WHOLE;
        end else if (in_character == adfp_pkg::CH_POINT) begin
          phase_nxt = adfp_pkg::PH_FRAC;
        end else begin
          phase_nxt = adfp_pkg::PH_DONE;
        end
      end
      adfp_pkg::PH_WHOLE: begin
        priority if (is_digit) begin
          whole_nxt = whole_x10;
        end else if (in_character == adfp_pkg::CH_POINT) begin
          phase_nxt = adfp_pkg::PH_FRAC;
        end else begin
          phase_nxt = adfp_pkg::PH_DONE;
        end
      end
      adfp_pkg::PH_FRAC: begin
        // digits beyond the scale end parsing
        if (is_digit && (cnt_r < scale)) begin
          frac_nxt = frac_x10;
          cnt_nxt  = cnt_r + 5'd1;
        end else begin
          phase_nxt = adfp_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // each stage moves when empty or when the stage after it moves
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= adfp_pkg::CFG_RESET;
      phase_r <= adfp_pkg::PH_START;
      minus_r <= 1'b0;
      whole_r <= '0;
      frac_r  <= '0;
      cnt_r   <= '0;
      v_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (accept) begin
        if (in_is_last) begin
          phase_r <= adfp_pkg::PH_START;
          minus_r <= 1'b0;
          whole_r <= '0;
          frac_r  <= '0;
          cnt_r   <= '0;
        end else begin
          phase_r <= phase_nxt;
          minus_r <= minus_nxt;
          whole_r <= whole_nxt;
          frac_r  <= frac_nxt;
          cnt_r   <= cnt_nxt;
        end
      end
      if (en[0]) begin
        v_r[0] <= accept && in_is_last;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // no padding when the scale was lowered below the digits already taken
  assign pad_exp = (p0_cnt_r < p0_scale_r) ? (p0_scale_r - p0_cnt_r) : '0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0_whole_r <= whole_nxt;
      p0_frac_r  <= frac_nxt;
      p0_cnt_r   <= cnt_nxt;
      p0_scale_r <= scale;
      sign_r[0]  <= minus_nxt;
    end
    if (en[1]) begin
      p1_whole_r <= p0_whole_r;
      p1_frac_r  <= p0_frac_r;
      p1_pw_r    <= adfp_pkg::pow_ten(p0_scale_r);
      p1_pf_r    <= adfp_pkg::pow_ten(pad_exp);
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (en[k]) begin
        sign_r[k] <= sign_r[k-1];
      end
    end
    if (en[NSTG-2]) begin
      sum_r <= whole_prod + frac_prod;
    end
    if (en[NSTG-1]) begin
      out_r <= sign_r[NSTG-2] ? (adfp_pkg::DATA_W'(0) - sum_r) : sum_r;
    end
  end

  adfp_mul64 u_mul_whole (
    .clk (clk),
    .en  (en[adfp_pkg::MUL_STG+1:2]),
    .a   (p1_whole_r),
    .b   (adfp_pkg::DATA_W'(p1_pw_r)),
    .p   (whole_prod)
  );

  adfp_mul64 u_mul_frac (
    .clk (clk),
    .en  (en[adfp_pkg::MUL_STG+1:2]),
    .a   (adfp_pkg::DATA_W'(p1_frac_r)),
    .b   (adfp_pkg::DATA_W'(p1_pf_r)),
    .p   (frac_prod)
  );

  assign out_valid    = v_r[NSTG-1];
  assign out_mantissa = out_r;

endmodule

// ===== rtl/adfp_mul64.sv =====
// 64x64 multiply modulo 2^64, built from three 32x32 products over four stages
module adfp_mul64 (
  input  logic                               clk,
  input  logic [adfp_pkg::MUL_STG-1:0]       en,
  input  logic [adfp_pkg::DATA_W-1:0]        a,
  input  logic [adfp_pkg::DATA_W-1:0]        b,
  output logic [adfp_pkg::DATA_W-1:0]        p
);

  logic [adfp_pkg::DATA_W-1:0] ll1_r, ll2_r, ll3_r, p_r;
  logic [adfp_pkg::HALF_W-1:0] a_hi1_r, b_lo1_r, a_lo1_r, b_hi1_r;
  logic [adfp_pkg::HALF_W-1:0] a_lo2_r, b_hi2_r;
  logic [adfp_pkg::HALF_W-1:0] c1_r, cross_r;
  logic [adfp_pkg::HALF_W-1:0] a_lo, b_lo;

  assign a_lo = a[adfp_pkg::HALF_W-1:0];
  assign b_lo = b[adfp_pkg::HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ll1_r   <= adfp_pkg::DATA_W'(a_lo) * adfp_pkg::DATA_W'(b_lo);
      a_hi1_r <= a[adfp_pkg::DATA_W-1:adfp_pkg::HALF_W];
      b_hi1_r <= b[adfp_pkg::DATA_W-1:adfp_pkg::HALF_W];
      a_lo1_r <= a_lo;
      b_lo1_r <= b_lo;
    end
    if (en[1]) begin
      // only the low half of a cross product survives the 2^64 wrap
      c1_r    <= a_hi1_r * b_lo1_r;
      ll2_r   <= ll1_r;
      a_lo2_r <= a_lo1_r;
      b_hi2_r <= b_hi1_r;
    end
    if (en[2]) begin
      cross_r <= c1_r + a_lo2_r * b_hi2_r;
      ll3_r   <= ll2_r;
    end
    if (en[3]) begin
      p_r <= ll3_r + {cross_r, {adfp_pkg::HALF_W{1'b0}}};
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/adfp_checker.sv =====
module adfp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [adfp_pkg::DATA_W-1:0] out_mantissa
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_mantissa))
    else $error("stalled result changed");

  // input backs up only when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind ascii_decimal_to_fixed_point_unit adfp_checker u_adfp_checker (.*);
